[hdl/psbt_pkg.sv]
// Shared types and constants for the per-slot status beacon throttle.
// No dependencies; every other file imports this package.
package psbt_pkg;

   localparam int MAX_SLOTS = 8;
   localparam int SLOT_W    = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;

   // Field widths fixed by the item format
   localparam int OP_W    = 2;
   localparam int SLOTF_W = 3;
   localparam int PHASE_W = 2;
   localparam int CNT_W   = 32;
   localparam int TIME_W  = 32;
   localparam int IVL_W   = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   localparam logic [IVL_W-1:0] INTERVAL_RESET = IVL_W'(1000);

   typedef enum logic [OP_W-1:0] {
      OP_NOTE   = 2'd0,
      OP_TICK   = 2'd1,
      OP_CANCEL = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE   = 1'd0,
      CSR_INTERVAL = 1'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic note_wr;
      logic cancel;
      logic clear_all;
      logic start;
      logic step;
      logic flush;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic enable;
      logic fire;
      logic hold_valid;
      logic out_free;
      logic at_last;
   } stat_type;

endpackage

[hdl/psbt_if.sv]
// Channel interfaces: request, beacon response and register write.
// Depends on psbt_pkg.
interface psbt_req_if;
   import psbt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [SLOTF_W-1:0]    slot;
   logic [PHASE_W-1:0]    phase;
   logic [CNT_W-1:0]      done_count;
   logic [CNT_W-1:0]      total_count;
   logic [TIME_W-1:0]     now_ms;
   modport source (output valid, operation, slot, phase, done_count, total_count, now_ms,
                   input ready);
   modport sink   (input valid, operation, slot, phase, done_count, total_count, now_ms,
                   output ready);
endinterface

interface psbt_rsp_if;
   import psbt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [SLOTF_W-1:0]    beacon_slot;
   logic [PHASE_W-1:0]    beacon_phase;
   logic [CNT_W-1:0]      beacon_done;
   logic [CNT_W-1:0]      beacon_total;
   logic                  last_of_tick;
   modport source (output valid, beacon_slot, beacon_phase, beacon_done, beacon_total,
                   last_of_tick, input ready);
   modport sink   (input valid, beacon_slot, beacon_phase, beacon_done, beacon_total,
                   last_of_tick, output ready);
endinterface

interface psbt_csr_if;
   import psbt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DAT_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/per_slot_status_beacon_throttle.sv]
// Per-slot status beacon throttle. Note, cancel and clear-all beats are taken
// while idle. A tick (with the enable register set) walks slots 1 to
// MAX_SLOTS-1, one slot per cycle through the slot store's single read port
// unless a held beacon must move out while the output is stalled, then flushes
// the final held beacon, if any, with its last mark. Ready stays low after the
// tick until the walk and any flush are done, so a stalled beacon output also
// delays the next beat. Beacons leave through a registered output; one beacon
// is held back internally so the last one of a tick can be marked.
// Depends on psbt_pkg, psbt_if.sv, psbt_ctrl and psbt_dp.
module per_slot_status_beacon_throttle (
   input  logic        clock,
   input  logic        reset,
   psbt_req_if.sink    req_chan,
   psbt_rsp_if.source  rsp_chan,
   psbt_csr_if.sink    csr_chan
);
   import psbt_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_chan.ready = req_ready;

   // Sequencer
   psbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Slot store and beacon path
   psbt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_slot  (req_chan.slot),
      .req_phase (req_chan.phase),
      .req_done  (req_chan.done_count),
      .req_total (req_chan.total_count),
      .req_now   (req_chan.now_ms),
      .csr       (csr_chan),
      .rsp       (rsp_chan),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

[hdl/psbt_ctrl.sv]
// Sequencer: decodes request beats and walks a tick over the slots.
// Depends on psbt_pkg; drives the datapath through cmd_type.
module psbt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [psbt_pkg::OP_W-1:0] req_op,
   output logic                req_ready,
   input  psbt_pkg::stat_type  stat,
   output psbt_pkg::cmd_type   cmd
);
   import psbt_pkg::*;

   state_type state_ff, state_in;
   op_type    op;

   assign op = op_type'(req_op);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (op)
                  OP_NOTE:   cmd.note_wr   = 1'b1;
                  OP_CANCEL: cmd.cancel    = 1'b1;
                  OP_CLEAR:  cmd.clear_all = 1'b1;
                  OP_TICK: begin
                     if (stat.enable) begin
                        cmd.start = 1'b1;
                        state_in  = ST_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            // stall only when a held beacon must move out and the output is busy
            if (!(stat.fire && stat.hold_valid && !stat.out_free)) begin
               cmd.step = 1'b1;
               if (stat.at_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!stat.hold_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[hdl/psbt_dp.sv]
// Datapath: per-slot note store, throttle check, held beacon and output register.
// Depends on psbt_pkg and the channel interfaces in psbt_if.sv.
module psbt_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic [psbt_pkg::SLOTF_W-1:0] req_slot,
   input  logic [psbt_pkg::PHASE_W-1:0] req_phase,
   input  logic [psbt_pkg::CNT_W-1:0]   req_done,
   input  logic [psbt_pkg::CNT_W-1:0]   req_total,
   input  logic [psbt_pkg::TIME_W-1:0]  req_now,
   psbt_csr_if.sink            csr,
   psbt_rsp_if.source          rsp,
   input  psbt_pkg::cmd_type   cmd,
   output psbt_pkg::stat_type  stat
);
   import psbt_pkg::*;

   // Config registers
   logic              enable_ff;
   logic [IVL_W-1:0]  interval_ff;

   // Per-slot state
   logic [MAX_SLOTS-1:0] pending_ff;
   logic [MAX_SLOTS-1:0] ever_ff;
   logic [PHASE_W-1:0]   note_phase_ff [MAX_SLOTS];
   logic [CNT_W-1:0]     note_done_ff  [MAX_SLOTS];
   logic [CNT_W-1:0]     note_total_ff [MAX_SLOTS];
   logic [PHASE_W-1:0]   att_phase_ff  [MAX_SLOTS];
   logic [TIME_W-1:0]    att_time_ff   [MAX_SLOTS];

   // Walk state
   logic [SLOT_W-1:0]    idx_ff;
   logic [TIME_W-1:0]    now_ff;

   // Held beacon (waits until we know whether it is the last one)
   logic                 hold_valid_ff;
   logic [SLOTF_W-1:0]   hold_slot_ff;
   logic [PHASE_W-1:0]   hold_phase_ff;
   logic [CNT_W-1:0]     hold_done_ff;
   logic [CNT_W-1:0]     hold_total_ff;

   // Output register
   logic                 rsp_valid_ff;
   logic [SLOTF_W-1:0]   rsp_slot_ff;
   logic [PHASE_W-1:0]   rsp_phase_ff;
   logic [CNT_W-1:0]     rsp_done_ff;
   logic [CNT_W-1:0]     rsp_total_ff;
   logic                 rsp_last_ff;

   logic                 slot_ok;
   logic [SLOT_W-1:0]    wr_idx;
   logic                 fresh;
   logic [TIME_W-1:0]    elapsed;
   logic                 fire;
   logic                 out_free;
   logic                 push_hold;

   // Request slot check and index
   assign slot_ok = (req_slot != '0) && (32'(req_slot) < 32'(MAX_SLOTS));
   assign wr_idx  = SLOT_W'(req_slot);

   // Throttle decision for the visited slot
   assign fresh   = !ever_ff[idx_ff] || (note_phase_ff[idx_ff] != att_phase_ff[idx_ff]);
   assign elapsed = now_ff - att_time_ff[idx_ff];
   assign fire    = pending_ff[idx_ff] && (fresh || (elapsed >= TIME_W'(interval_ff)));

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign push_hold = (cmd.step && fire && hold_valid_ff) || cmd.flush;

   assign stat.enable     = enable_ff;
   assign stat.fire       = fire;
   assign stat.hold_valid = hold_valid_ff;
   assign stat.out_free   = out_free;
   assign stat.at_last    = (idx_ff == SLOT_W'(MAX_SLOTS - 1));

   // Config port, always ready
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         interval_ff <= INTERVAL_RESET;
      end else if (csr.valid) begin
         unique case (csr_idx_type'(csr.index))
            CSR_ENABLE:   enable_ff   <= csr.data[0];
            CSR_INTERVAL: interval_ff <= csr.data[IVL_W-1:0];
            default: ;
         endcase
      end
   end

   // Slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         ever_ff    <= '0;
      end else if (cmd.clear_all) begin
         pending_ff <= '0;
         ever_ff    <= '0;
      end else if (cmd.cancel && slot_ok) begin
         pending_ff[wr_idx] <= 1'b0;
         ever_ff[wr_idx]    <= 1'b0;
      end else if (cmd.note_wr && slot_ok) begin
         pending_ff[wr_idx] <= 1'b1;
      end else if (cmd.step) begin
         pending_ff[idx_ff] <= 1'b0;
         if (fire) begin
            ever_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // Slot payload
   always_ff @(posedge clock) begin
      if (cmd.note_wr && slot_ok) begin
         note_phase_ff[wr_idx] <= req_phase;
         note_done_ff[wr_idx]  <= req_done;
         note_total_ff[wr_idx] <= req_total;
      end
      if (cmd.step && fire) begin
         att_phase_ff[idx_ff] <= note_phase_ff[idx_ff];
         att_time_ff[idx_ff]  <= now_ff;
      end
   end

   // Walk counter and tick time
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= SLOT_W'(1);
      end else if (cmd.start) begin
         idx_ff <= SLOT_W'(1);
      end else if (cmd.step) begin
         idx_ff <= idx_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         now_ff <= req_now;
      end
   end

   // Held beacon
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (cmd.step && fire) begin
         hold_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && fire) begin
         hold_slot_ff  <= SLOTF_W'(idx_ff);
         hold_phase_ff <= note_phase_ff[idx_ff];
         hold_done_ff  <= note_done_ff[idx_ff];
         hold_total_ff <= note_total_ff[idx_ff];
      end
   end

   // Output register; last mark set only by the end-of-walk flush
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_hold) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_hold) begin
         rsp_slot_ff  <= hold_slot_ff;
         rsp_phase_ff <= hold_phase_ff;
         rsp_done_ff  <= hold_done_ff;
         rsp_total_ff <= hold_total_ff;
         rsp_last_ff  <= cmd.flush;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.beacon_slot  = rsp_slot_ff;
   assign rsp.beacon_phase = rsp_phase_ff;
   assign rsp.beacon_done  = rsp_done_ff;
   assign rsp.beacon_total = rsp_total_ff;
   assign rsp.last_of_tick = rsp_last_ff;

endmodule

[tb/sv/per_slot_status_beacon_throttle_test.sv]
// Self-checking testbench for per_slot_status_beacon_throttle: random and directed
// note/tick/cancel/clear beats, beacons checked against an in-bench predictor.
// Depends on psbt_pkg, psbt_if.sv and the RTL of the throttle.
`timescale 1ns / 100ps

module per_slot_status_beacon_throttle_test;
   import psbt_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int CYCLE_LIMIT = 200000;
   // A tick with no beacon can still be walking when the last beacon lands
   localparam int SETTLE      = MAX_SLOTS + 8;

   typedef struct packed {
      op_type             op;
      logic [SLOTF_W-1:0] slot;
      logic [PHASE_W-1:0] phase;
      logic [CNT_W-1:0]   done_count;
      logic [CNT_W-1:0]   total_count;
      logic [TIME_W-1:0]  now_ms;
   } request_type;

   typedef struct packed {
      logic [SLOTF_W-1:0] slot;
      logic [PHASE_W-1:0] phase;
      logic [CNT_W-1:0]   done_count;
      logic [CNT_W-1:0]   total_count;
      logic               last_of_tick;
   } beacon_type;

   // Throttle predictor plus the queue of beacons still owed by the block
   class beacon_scoreboard;
      bit                 enabled;
      logic [IVL_W-1:0]   min_gap;
      bit                 armed        [MAX_SLOTS];
      logic [PHASE_W-1:0] stored_phase [MAX_SLOTS];
      logic [CNT_W-1:0]   stored_done  [MAX_SLOTS];
      logic [CNT_W-1:0]   stored_total [MAX_SLOTS];
      bit                 sent_once    [MAX_SLOTS];
      logic [PHASE_W-1:0] sent_phase   [MAX_SLOTS];
      logic [TIME_W-1:0]  sent_at      [MAX_SLOTS];
      beacon_type         expected_beacons[$];
      int unsigned        errors;

      function new();
         enabled = 1'b0;
         min_gap = INTERVAL_RESET;
         errors  = 0;
         for (int s = 0; s < MAX_SLOTS; s++) clear_slot(s);
      endfunction

      function void clear_slot(int s);
         armed[s]        = 1'b0;
         stored_phase[s] = '0;
         stored_done[s]  = '0;
         stored_total[s] = '0;
         sent_once[s]    = 1'b0;
         sent_phase[s]   = '0;
         sent_at[s]      = '0;
      endfunction

      function void note_config(csr_idx_type idx, logic [CSR_DAT_W-1:0] value);
         if (idx == CSR_ENABLE) enabled = value[0];
         else min_gap = value[IVL_W-1:0];
      endfunction

      // Apply one accepted request beat; a tick queues the beacons it owes
      function void note_request(request_type r);
         bit                slot_ok;
         bit                fresh;
         bit                have_held;
         beacon_type        held;
         logic [TIME_W-1:0] elapsed;
         slot_ok   = int'(r.slot) >= 1 && int'(r.slot) < MAX_SLOTS;
         have_held = 1'b0;
         held      = '0;
         case (r.op)
            OP_NOTE: begin
               if (slot_ok) begin
                  armed[r.slot]        = 1'b1;
                  stored_phase[r.slot] = r.phase;
                  stored_done[r.slot]  = r.done_count;
                  stored_total[r.slot] = r.total_count;
               end
            end
            OP_CANCEL: begin
               if (slot_ok) clear_slot(int'(r.slot));
            end
            OP_CLEAR: begin
               for (int s = 0; s < MAX_SLOTS; s++) clear_slot(s);
            end
            default: begin
               if (enabled) begin
                  for (int s = 1; s < MAX_SLOTS; s++) begin
                     if (!armed[s]) continue;
                     armed[s] = 1'b0;
                     fresh    = !sent_once[s] || stored_phase[s] != sent_phase[s];
                     elapsed  = r.now_ms - sent_at[s];
                     if (!fresh && elapsed < TIME_W'(min_gap)) continue;
                     sent_once[s]  = 1'b1;
                     sent_phase[s] = stored_phase[s];
                     sent_at[s]    = r.now_ms;
                     // hold one beacon back so the final one can carry the mark
                     if (have_held) expected_beacons.push_back(held);
                     held.slot         = SLOTF_W'(s);
                     held.phase        = stored_phase[s];
                     held.done_count   = stored_done[s];
                     held.total_count  = stored_total[s];
                     held.last_of_tick = 1'b0;
                     have_held         = 1'b1;
                  end
                  if (have_held) begin
                     held.last_of_tick = 1'b1;
                     expected_beacons.push_back(held);
                  end
               end
            end
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("%0t ns  MISMATCH  %s", $realtime, msg);
      endtask

      task check_beacon(beacon_type got);
         beacon_type want;
         if (expected_beacons.size() == 0) begin
            report($sformatf("unexpected beacon slot=%0d phase=%0d done=%h total=%h last=%0d",
                             got.slot, got.phase, got.done_count, got.total_count,
                             got.last_of_tick));
         end else begin
            want = expected_beacons.pop_front();
            if (got !== want)
               report($sformatf({"beacon got slot=%0d phase=%0d done=%h total=%h last=%0d",
                                 " want slot=%0d phase=%0d done=%h total=%h last=%0d"},
                                got.slot, got.phase, got.done_count, got.total_count,
                                got.last_of_tick, want.slot, want.phase, want.done_count,
                                want.total_count, want.last_of_tick));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   psbt_req_if req_bus();
   psbt_rsp_if rsp_bus();
   psbt_csr_if csr_bus();

   per_slot_status_beacon_throttle uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   beacon_scoreboard sb;
   int               send_idle = 28;
   int               recv_idle = 65;
   int unsigned      cycle_count = 0;
   logic [TIME_W-1:0] clock_ms;
   int               gap_now;
   logic [PHASE_W-1:0] slot_phase [MAX_SLOTS];

   always #HALF_PERIOD clock = ~clock;

   // Receiver backpressure, changed on the falling edge
   always @(negedge clock) rsp_bus.ready = ($urandom_range(99) >= recv_idle);

   // Sample every handshake at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            sb.note_config(csr_idx_type'(csr_bus.index), csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            sb.note_request('{op: op_type'(req_bus.operation), slot: req_bus.slot,
                              phase: req_bus.phase, done_count: req_bus.done_count,
                              total_count: req_bus.total_count, now_ms: req_bus.now_ms});
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_beacon('{slot: rsp_bus.beacon_slot, phase: rsp_bus.beacon_phase,
                              done_count: rsp_bus.beacon_done,
                              total_count: rsp_bus.beacon_total,
                              last_of_tick: rsp_bus.last_of_tick});
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // Drive one request beat; called and returns at a falling edge
   task automatic issue(input op_type op, input logic [SLOTF_W-1:0] slot,
                        input logic [PHASE_W-1:0] phase, input logic [CNT_W-1:0] done,
                        input logic [CNT_W-1:0] total, input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.operation   = op;
      req_bus.slot        = slot;
      req_bus.phase       = phase;
      req_bus.done_count  = done;
      req_bus.total_count = total;
      req_bus.now_ms      = now;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic write_register(input csr_idx_type idx, input logic [CSR_DAT_W-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Stop sending until every owed beacon is back, then let the block settle
   task automatic hold_until_drained(input int settle);
      req_bus.valid = 1'b0;
      while (sb.expected_beacons.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // One random beat, mostly notes and ticks so the throttle gets exercised
   task automatic random_beat();
      int                 pick;
      logic [SLOTF_W-1:0] slot;
      pick = $urandom_range(99);
      slot = ($urandom_range(99) < 8) ? '0 : SLOTF_W'($urandom_range(MAX_SLOTS - 1, 1));
      if (pick < 55) begin
         if ($urandom_range(99) < 25) slot_phase[slot] = PHASE_W'($urandom_range(3));
         issue(OP_NOTE, slot, slot_phase[slot], $urandom, $urandom, $urandom);
      end else if (pick < 88) begin
         if ($urandom_range(99) < 6) clock_ms = $urandom;
         else clock_ms = clock_ms + TIME_W'($urandom_range(0, 2 * gap_now + 2));
         issue(OP_TICK, SLOTF_W'($urandom), PHASE_W'($urandom), $urandom, $urandom,
               clock_ms);
      end else if (pick < 97) begin
         issue(OP_CANCEL, SLOTF_W'($urandom), PHASE_W'($urandom), $urandom, $urandom,
               $urandom);
      end else begin
         issue(OP_CLEAR, SLOTF_W'($urandom), PHASE_W'($urandom), $urandom, $urandom,
               $urandom);
      end
   endtask

   initial begin
      int count;
      sb = new();
      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_NOTE;
      req_bus.slot        = '0;
      req_bus.phase       = '0;
      req_bus.done_count  = '0;
      req_bus.total_count = '0;
      req_bus.now_ms      = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_ENABLE;
      csr_bus.data        = '0;
      for (int s = 0; s < MAX_SLOTS; s++) slot_phase[s] = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: disabled tick keeps the note armed
      issue(OP_NOTE, 1, 0, 32'h0, 32'hFFFF_FFFF, 0);
      issue(OP_TICK, 0, 0, 0, 0, 0);
      hold_until_drained(SETTLE);
      write_register(CSR_ENABLE, 1);
      issue(OP_TICK, 0, 0, 0, 0, 0);
      // slot 0 ignored; same phase just inside the interval is held back
      issue(OP_NOTE, 0, 2, 32'h1234_5678, 32'h9ABC_DEF0, 0);
      issue(OP_NOTE, 7, 3, 32'hFFFF_FFFF, 32'h0, 0);
      issue(OP_NOTE, 1, 0, 5, 6, 0);
      issue(OP_TICK, 0, 0, 0, 0, 999);
      issue(OP_NOTE, 1, 0, 7, 8, 0);
      issue(OP_TICK, 0, 0, 0, 0, 1000);
      // every slot at once: the largest burst
      for (int s = 1; s < MAX_SLOTS; s++)
         issue(OP_NOTE, SLOTF_W'(s), PHASE_W'(s), CNT_W'(s), ~CNT_W'(s), 0);
      issue(OP_TICK, 0, 0, 0, 0, 3000);
      // cancel forgets the last attempt; cancel of slot 0 does nothing
      issue(OP_CANCEL, 7, 0, 0, 0, 0);
      issue(OP_CANCEL, 0, 0, 0, 0, 0);
      issue(OP_NOTE, 7, 3, 1, 2, 0);
      issue(OP_TICK, 0, 0, 0, 0, 3001);
      // clear-all, then time wrapping past 2^32
      issue(OP_CLEAR, 0, 0, 0, 0, 0);
      issue(OP_NOTE, 2, 1, 3, 4, 0);
      issue(OP_TICK, 7, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
      issue(OP_NOTE, 2, 1, 5, 6, 0);
      issue(OP_TICK, 0, 0, 0, 0, 32'h0000_0010);

      // Random sections, each with its own register settings; the first three also set their own idling
      for (int sec = 0; sec < 5; sec++) begin
         hold_until_drained(SETTLE);
         case (sec)
            0: begin
               send_idle = 28; recv_idle = 65; count = 40;
               gap_now = $urandom_range(50, 400); clock_ms = $urandom;
               write_register(CSR_INTERVAL, CSR_DAT_W'(gap_now));
            end
            1: begin
               send_idle = 65; recv_idle = 28; count = 40;
               gap_now = 65535; clock_ms = 32'hFFFF_0000;
               write_register(CSR_INTERVAL, CSR_DAT_W'(gap_now));
            end
            2: begin
               send_idle = 0; recv_idle = 0; count = 35;
               gap_now = 0;
               write_register(CSR_INTERVAL, CSR_DAT_W'(gap_now));
            end
            3: begin
               count = 12;
               gap_now = 1;
               write_register(CSR_INTERVAL, CSR_DAT_W'(gap_now));
               write_register(CSR_ENABLE, 0);
            end
            default: begin
               count = 30;
               gap_now = $urandom_range(1, 2000);
               write_register(CSR_INTERVAL, CSR_DAT_W'(gap_now));
               write_register(CSR_ENABLE, 1);
            end
         endcase
         for (int n = 0; n < count; n++) begin
            if (n == count / 2 || $urandom_range(99) < 3) hold_until_drained(0);
            random_beat();
         end
      end

      hold_until_drained(SETTLE * 2);
      if (sb.errors == 0 && sb.expected_beacons.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
